// ===== rtl/adaptive_bit_probability_table_macros.svh =====
// assertion macros used by the bit probability table controller
`ifndef ADAPTIVE_BIT_PROBABILITY_TABLE_MACROS_SVH
`define ADAPTIVE_BIT_PROBABILITY_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ABPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ABPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/abpt_pkg.sv =====
// shared constants and control types of the bit probability table
`timescale 1ns / 1ps
package abpt_pkg;

  // geometry of the entry store
  localparam int CTX_W     = 8;
  localparam int NODE_W    = 8;
  localparam int NODES     = 255;
  localparam int ADDR_W    = CTX_W + NODE_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // entry layout: hit count over probability
  localparam int PROB_W  = 16;
  localparam int CNT_W   = 8;
  localparam int ENTRY_W = CNT_W + PROB_W;

  // update numerator width (p*(c-1) + one + c/2 stays below 2^24)
  localparam int NUM_W = 24;

  localparam logic [PROB_W-1:0] HALF_PROB   = 16'h8000;
  localparam logic [PROB_W-1:0] MAX_PROB    = 16'hFFFF;
  localparam logic [NUM_W-1:0]  ONE_PROB    = 24'h01_0000;
  localparam logic [CNT_W-1:0]  LIMIT_RESET = 8'd255;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // operation codes
  localparam logic OP_READ   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic rd;
    logic mix;
    logic finish;
  } abpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_done;
  } abpt_sts_t;

endpackage

// ===== rtl/abpt_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module abpt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [abpt_pkg::NUM_W-1:0] num_i,
  input  logic [abpt_pkg::CNT_W-1:0] den_i,
  output logic                      done_o,
  output logic [abpt_pkg::NUM_W-1:0] quo_o
);
  import abpt_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  dq_q, dq_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, dq_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    dq_d   = dq_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = den_i;
      dq_d   = num_i;
    end else if (busy_q) begin
      rem_d  = fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
      dq_d   = {dq_q[NUM_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // operand and quotient shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dq_q  <= dq_d;
  end

  // quotient is complete after the cycle that flags done
  assign done_o = busy_q && (step_q == LAST_STEP);
  assign quo_o  = dq_q;

endmodule

// ===== rtl/abpt_dp.sv =====
// datapath: entry store, clearing sweep, count and probability update
`timescale 1ns / 1ps
module abpt_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  abpt_pkg::abpt_cmd_t             cmd_i,
  output abpt_pkg::abpt_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [abpt_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                            operation_i,
  input  logic [abpt_pkg::CTX_W-1:0]      context_req_i,
  input  logic [abpt_pkg::NODE_W-1:0]     tree_node_i,
  input  logic                            coded_bit_i,
  output logic [abpt_pkg::PROB_W-1:0]     probability_o
);
  import abpt_pkg::*;

  logic [ENTRY_W-1:0] mem_q [MEM_DEPTH];

  logic [CNT_W-1:0]  count_limit_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              op_q, bit_q;
  logic [CTX_W-1:0]  row_q;
  logic [NODE_W-1:0] node_q;
  logic [ENTRY_W-1:0] rd_q;
  logic [CNT_W-1:0]  cnt_new_q, cnt_new_d;
  logic [PROB_W-1:0] out_q;

  logic [ADDR_W-1:0]  addr;
  logic               node_ok;
  logic [CNT_W-1:0]   cnt_old;
  logic [PROB_W-1:0]  p_old;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   div_c;
  logic [NUM_W-1:0]   num;
  logic               div_done;
  logic [NUM_W-1:0]   quo;
  logic [PROB_W-1:0]  result;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;

  assign addr    = {row_q, node_q};
  assign node_ok = node_q < NODE_W'(NODES);
  assign cnt_old = rd_q[ENTRY_W-1:PROB_W];
  assign p_old   = rd_q[PROB_W-1:0];

  // count limit register, zero acts as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      count_limit_q <= cfg_wdata_i;
    end
  end
  assign lim = (count_limit_q == '0) ? CNT_W'(1) : count_limit_q;

  // clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      row_q  <= context_req_i;
      node_q <= tree_node_i;
      bit_q  <= coded_bit_i;
    end
  end

  // raised count and divisor; a lowered limit keeps the stored count
  always_comb begin
    if (cnt_old < lim) begin
      cnt_new_d = cnt_old + 1'b1;
      div_c     = cnt_new_d;
    end else begin
      cnt_new_d = cnt_old;
      div_c     = lim;
    end
  end

  // numerator p*(c-1) + target + c/2
  assign num = NUM_W'(p_old) * NUM_W'(div_c - CNT_W'(1))
             + (bit_q ? ONE_PROB : '0)
             + NUM_W'(div_c >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      cnt_new_q <= cnt_new_d;
    end
  end

  abpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mix && sts_o.need_div),
    .num_i   (num),
    .den_i   (div_c),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // result select with clamp
  always_comb begin
    if (!node_ok) begin
      result = HALF_PROB;
    end else if (op_q == OP_READ) begin
      result = p_old;
    end else if (quo > NUM_W'(MAX_PROB)) begin
      result = MAX_PROB;
    end else begin
      result = quo[PROB_W-1:0];
    end
  end

  // store write port: clearing sweep or update write-back
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {cnt_new_q, result};
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = {{CNT_W{1'b0}}, HALF_PROB};
    end else if (cmd_i.finish && sts_o.need_div) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem_q[addr];
    end
  end

  // output data register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  assign probability_o   = out_q;
  assign sts_o.clr_last  = &clr_addr_q;
  assign sts_o.need_div  = (op_q == OP_UPDATE) && node_ok;
  assign sts_o.div_done  = div_done;

endmodule

// ===== rtl/abpt_ctrl.sv =====
// controller: clearing sweep, item sequencing and output valid
`timescale 1ns / 1ps
module abpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output abpt_pkg::abpt_cmd_t cmd_o,
  input  abpt_pkg::abpt_sts_t sts_i
);
  import abpt_pkg::*;
  `include "adaptive_bit_probability_table_macros.svh"

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MIX,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    m_valid_d     = m_valid_q && !m_ready_i;
    cmd_o         = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = sts_i.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // checks
  `ABPT_ASSERT_NOW(a_div_done_in_div, clk_i, rst_ni, sts_i.div_done, state_q == ST_DIV, "divider done outside divide state")
  `ABPT_ASSERT_NEXT(a_finish_sets_valid, clk_i, rst_ni, cmd_o.finish, m_valid_q, "finished item not presented")
  `ABPT_ASSERT_NEXT(a_hold_pending, clk_i, rst_ni, (state_q == ST_DONE) && m_valid_q && !m_ready_i, state_q == ST_DONE, "waiting result overwritten")
  `ABPT_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, cmd_o.clr_wr, !cmd_o.capture && !cmd_o.finish, "item activity during clearing sweep")

endmodule

// ===== rtl/adaptive_bit_probability_table.sv =====
// top level of the adaptive bit probability table
//
//   channel   direction  contents
//   s_axis    in         tuser: operation; tdata: context_req, tree_node, coded_bit
//   m_axis    out        tdata: probability
//   cfg       in         count_limit write
//
// a read item passes the entry read, the count and numerator step and the finish step before
// the next accept; an update also runs a restoring divider for (p*(c-1) + bit + c/2) / c.
// the result of either is presented from the output register written at the finish step.
// a node past the end of the row skips the divider and is sequenced like a read.
// after reset a clearing sweep writes all 65536 entries, one a cycle, while no item
// is accepted; count_limit writes are taken throughout.
// a result waiting on m_axis_tready lets the next item in but holds it at its finish step.
`timescale 1ns / 1ps
module adaptive_bit_probability_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [abpt_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] context_req, [15:8] tree_node, [16] coded_bit, [23:17] zero
  input  logic [abpt_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [0] operation
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [15:0] probability
  output logic [abpt_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import abpt_pkg::*;

  abpt_cmd_t cmd;
  abpt_sts_t sts;

  abpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  abpt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (s_axis_tuser_i),
    .context_req_i (s_axis_tdata_i[CTX_W-1:0]),
    .tree_node_i   (s_axis_tdata_i[CTX_W+NODE_W-1:CTX_W]),
    .coded_bit_i   (s_axis_tdata_i[CTX_W+NODE_W]),
    .probability_o (m_axis_tdata_o)
  );

endmodule

// ===== verif/tb.sv =====
// self-checking stream testbench for the adaptive bit probability table
`timescale 1ns / 1ps
module tb;
  import abpt_pkg::*;

  localparam int CONTEXTS     = 256;
  localparam int ENTRIES      = CONTEXTS * NODES;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int HOT_ENTRIES  = 8;
  localparam int IDLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  // one row of the directed part; check_fixed selects the typed-in value
  typedef struct packed {
    logic              op;
    logic [CTX_W-1:0]  ctx;
    logic [NODE_W-1:0] node;
    logic              coded;
    logic              check_fixed;
    logic [PROB_W-1:0] fixed_prob;
  } prob_row_t;

  localparam int DIRECTED_ROWS = 22;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_DATA_W-1:0]   s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata_o;

  // typed-in expectation that travels with the item on the bus
  logic                   cur_check_fixed = 1'b0;
  logic [PROB_W-1:0]      cur_fixed_prob = '0;

  // predictor state
  logic [PROB_W-1:0]      prob_mirror [ENTRIES];
  logic [CNT_W-1:0]       hits_mirror [ENTRIES];
  logic [CNT_W-1:0]       limit_mirror = LIMIT_RESET;

  logic [PROB_W-1:0]      prob_expect_q [$];
  int                     fail_count = 0;

  // sender pacing
  int                     burst_left = 0;

  // hot entries that the well-formed sequences keep revisiting
  logic [CTX_W-1:0]       hot_ctx  [HOT_ENTRIES];
  logic [NODE_W-1:0]      hot_node [HOT_ENTRIES];

  prob_row_t directed_rows [DIRECTED_ROWS] = '{
    // reads straight after the clearing sweep
    '{OP_READ,   8'd0,   8'd0,   1'b0, 1'b1, HALF_PROB},
    '{OP_READ,   8'd255, 8'd254, 1'b1, 1'b1, HALF_PROB},
    // node past the end of the row
    '{OP_READ,   8'd0,   8'd255, 1'b0, 1'b1, HALF_PROB},
    '{OP_UPDATE, 8'd170, 8'd255, 1'b1, 1'b1, HALF_PROB},
    '{OP_READ,   8'd85,  8'd255, 1'b1, 1'b1, HALF_PROB},
    // first update jumps to the bit, clamped below one
    '{OP_UPDATE, 8'd0,   8'd0,   1'b1, 1'b1, MAX_PROB},
    '{OP_READ,   8'd0,   8'd0,   1'b0, 1'b1, MAX_PROB},
    '{OP_UPDATE, 8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{OP_UPDATE, 8'd255, 8'd254, 1'b0, 1'b1, 16'd0},
    '{OP_READ,   8'd255, 8'd254, 1'b1, 1'b1, 16'd0},
    '{OP_UPDATE, 8'd255, 8'd254, 1'b1, 1'b0, '0},
    // count runs into the limit
    '{OP_UPDATE, 8'd85,  8'd170, 1'b1, 1'b0, '0},
    '{OP_UPDATE, 8'd85,  8'd170, 1'b1, 1'b0, '0},
    '{OP_UPDATE, 8'd85,  8'd170, 1'b1, 1'b0, '0},
    '{OP_UPDATE, 8'd85,  8'd170, 1'b1, 1'b0, '0},
    '{OP_UPDATE, 8'd85,  8'd170, 1'b1, 1'b0, '0},
    '{OP_READ,   8'd85,  8'd170, 1'b0, 1'b0, '0},
    '{OP_UPDATE, 8'd85,  8'd170, 1'b0, 1'b0, '0},
    '{OP_UPDATE, 8'd170, 8'd85,  1'b0, 1'b0, '0},
    '{OP_READ,   8'd170, 8'd85,  1'b1, 1'b0, '0},
    '{OP_UPDATE, 8'd1,   8'd128, 1'b1, 1'b0, '0},
    '{OP_UPDATE, 8'd128, 8'd127, 1'b0, 1'b0, '0}
  };

  adaptive_bit_probability_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // probability that the table returns for one item; updates the mirror
  function automatic logic [PROB_W-1:0] predict_prob(logic op, logic [CTX_W-1:0] ctx,
                                                     logic [NODE_W-1:0] node, logic coded);
    int unsigned idx;
    int unsigned p;
    int unsigned c;
    int unsigned lim;
    int unsigned num;
    int unsigned res;
    if (node >= NODES) return HALF_PROB;
    idx = int'(ctx) * NODES + int'(node);
    p = prob_mirror[idx];
    if (op == OP_READ) return PROB_W'(p);
    lim = (limit_mirror == 0) ? 1 : int'(limit_mirror);
    c = hits_mirror[idx];
    if (c < lim) begin
      c++;
      hits_mirror[idx] = CNT_W'(c);
    end else begin
      c = lim;
    end
    num = p * (c - 1) + (coded ? int'(ONE_PROB) : 0) + (c >> 1);
    res = num / c;
    if (res > int'(MAX_PROB)) res = MAX_PROB;
    prob_mirror[idx] = PROB_W'(res);
    return PROB_W'(res);
  endfunction

  // predict on every accepted item, check every accepted result
  always @(posedge clk_i) begin : scoreboard
    logic [PROB_W-1:0] predicted;
    logic [PROB_W-1:0] wanted;
    if (cfg_we_i) limit_mirror = cfg_wdata_i;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predicted = predict_prob(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[15:8],
                               s_axis_tdata_i[16]);
      prob_expect_q = {prob_expect_q, (cur_check_fixed ? cur_fixed_prob : predicted)};
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (prob_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: probability %0d", m_axis_tdata_o);
      end else begin
        wanted = prob_expect_q.pop_front();
        if (m_axis_tdata_o !== wanted) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("probability mismatch: expected %0d actual %0d", wanted, m_axis_tdata_o);
        end
      end
    end
  end

  // cycles without any item moving on either side
  always @(posedge clk_i) begin : watchdog
    static int idle_cycles = 0;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: switches between always ready, coin-flip and long stalls
  always @(negedge clk_i) begin : result_sink
    static int mode = 0;
    static int mode_left = 0;
    static int stall_left = 0;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    case (mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
        end
      end
    endcase
  end

  task automatic write_limit(logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // present one item and hold it until taken, then maybe open a gap
  task automatic send_item(logic op, logic [CTX_W-1:0] ctx, logic [NODE_W-1:0] node,
                           logic coded, logic check_fixed, logic [PROB_W-1:0] fixed_prob);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {7'd0, coded, node, ctx};
    cur_check_fixed <= check_fixed;
    cur_fixed_prob <= fixed_prob;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    cur_check_fixed <= 1'b0;
    while (prob_expect_q.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin : stimulus
    static int phase_limit [PHASES] = '{255, 17, 0, 1, 2, 128, -1, 255};
    static int phase_bias  [PHASES] = '{95, 50, 5, 50, 100, 0, 50, 30};
    static int phase_hot   [PHASES] = '{1, 1, 2, 4, 2, 8, 4, 8};
    int sent;
    int pick;
    int h;
    logic coded;
    for (int i = 0; i < ENTRIES; i++) begin
      prob_mirror[i] = HALF_PROB;
      hits_mirror[i] = '0;
    end
    for (int i = 0; i < HOT_ENTRIES; i++) begin
      hot_ctx[i] = CTX_W'($urandom_range(0, CONTEXTS - 1));
      hot_node[i] = NODE_W'($urandom_range(0, NODES - 1));
    end

    // reset, then a small limit so the directed rows reach saturation
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_limit(8'd3);

    // directed rows
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ctx, directed_rows[i].node,
                directed_rows[i].coded, directed_rows[i].check_fixed,
                directed_rows[i].fixed_prob);

    // random phases, each under its own count limit
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_limit(phase_limit[ph] < 0 ? CNT_W'($urandom_range(1, 254))
                                      : CNT_W'(phase_limit[ph]));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        h = $urandom_range(0, phase_hot[ph] - 1);
        coded = ($urandom_range(0, 99) < phase_bias[ph]);
        if (pick < 70) begin
          // compressor loop: read then update the same entry
          send_item(OP_READ, hot_ctx[h], hot_node[h], 1'($urandom_range(0, 1)), 1'b0, '0);
          send_item(OP_UPDATE, hot_ctx[h], hot_node[h], coded, 1'b0, '0);
          sent += 2;
        end else if (pick < 80) begin
          send_item(OP_UPDATE, CTX_W'($urandom_range(0, CONTEXTS - 1)),
                    NODE_W'($urandom_range(0, NODES - 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end else if (pick < 88) begin
          send_item(OP_READ, CTX_W'($urandom_range(0, CONTEXTS - 1)),
                    NODE_W'($urandom_range(0, NODES - 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end else if (pick < 94) begin
          // node past the end of the row
          send_item(1'($urandom_range(0, 1)), CTX_W'($urandom_range(0, CONTEXTS - 1)),
                    NODE_W'(NODES), 1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end else begin
          send_item(OP_UPDATE, hot_ctx[h], hot_node[h], coded, 1'b0, '0);
          sent++;
        end
      end
    end

    // wait out the last results, then report
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && prob_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/abpt_pkg.sv
rtl/abpt_div.sv
rtl/abpt_dp.sv
rtl/abpt_ctrl.sv
rtl/adaptive_bit_probability_table.sv
verif/tb.sv
